@@ rtl/ssi_pkg.sv @@
// shared types and constants for the sorted set intersection block
// no dependencies; every other rtl file uses this package by scoped names
package ssi_pkg;

   // list storage sizing
   localparam int LIST_DEPTH = 64;
   localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int VALUE_W = 32;

   // command codes of the input item
   typedef enum logic [1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_START  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // input item
   typedef struct packed {
      logic [1:0]                 cmd;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   // result item
   typedef struct packed {
      logic signed [VALUE_W-1:0]  common_value;
      logic                       last;
      logic                       empty_res;
      logic                       overflow;
   } rsp_type;

   // queued command for the back end
   typedef struct packed {
      cmd_type                    cmd;
      logic signed [VALUE_W-1:0]  value;
   } qentry_type;

endpackage

@@ rtl/sorted_set_intersection.sv @@
// Sorted set intersection. Load items (cmd 0 for list A, cmd 1 for list B)
// append a signed 32-bit value to a list of up to 64 entries; loads into a
// full list are dropped and reported through the overflow bit of the next
// start's results. A start item (cmd 2) walks both lists with two pointers
// and returns each common value in ascending order, the final one marked
// last, or a single item with empty_res and last set when nothing matches;
// the start then clears both lists. The back end writes a load while in
// ST_IDLE. Each walk step of a start passes through ST_READ and ST_CMP,
// since it waits on the registered read port of the list memories; a start
// with either list empty goes straight to ST_FLUSH, and the walk also waits
// while the result side stalls. A four-item command queue lets loads be
// accepted during a walk.
// Depends on ssi_pkg, ssi_front, ssi_queue and ssi_back.
module sorted_set_intersection (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ssi_pkg::req_type  req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ssi_pkg::rsp_type  rsp_item
);

   logic                 q_full;
   logic                 push;
   ssi_pkg::qentry_type  push_entry;
   logic                 pop;
   logic                 q_valid;
   ssi_pkg::qentry_type  q_entry;

   // accept and decode
   ssi_front u_front (
      .req_valid  (req_valid),
      .req_item   (req_item),
      .req_stall  (req_stall),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // command queue
   ssi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_entry    (q_entry)
   );

   // lists and merge walk
   ssi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

@@ rtl/ssi_front.sv @@
// front end: accepts input items, decodes the command, drops unused codes
// depends on ssi_pkg; feeds ssi_queue
module ssi_front (
   input  logic                 req_valid,
   input  ssi_pkg::req_type     req_item,
   output logic                 req_stall,
   input  logic                 q_full,
   output logic                 push,
   output ssi_pkg::qentry_type  push_entry
);

   logic accept;

   // stall only when the queue has no room
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // decode command; the unused code is consumed with no effect
   always_comb begin
      push_entry.value = req_item.value;
      push             = 1'b0;
      case (req_item.cmd)
         ssi_pkg::CMD_LOAD_A: begin
            push_entry.cmd = ssi_pkg::CMD_LOAD_A;
            push           = accept;
         end
         ssi_pkg::CMD_LOAD_B: begin
            push_entry.cmd = ssi_pkg::CMD_LOAD_B;
            push           = accept;
         end
         ssi_pkg::CMD_START: begin
            push_entry.cmd = ssi_pkg::CMD_START;
            push           = accept;
         end
         default: begin
            push_entry.cmd = ssi_pkg::CMD_NONE;
            push           = 1'b0;
         end
      endcase
   end

endmodule

@@ rtl/ssi_queue.sv @@
// short command queue that decouples the front end from the back end
// depends on ssi_pkg
module ssi_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ssi_pkg::qentry_type  push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 q_valid,
   output ssi_pkg::qentry_type  q_entry
);

   ssi_pkg::qentry_type           slot_ff [ssi_pkg::QUEUE_DEPTH];
   logic [ssi_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ssi_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ssi_pkg::QCNT_W-1:0]    fill_ff, fill_in;
   logic                          do_push, do_pop;

   assign full    = (fill_ff == ssi_pkg::QCNT_W'(ssi_pkg::QUEUE_DEPTH));
   assign q_valid = (fill_ff != '0);
   assign q_entry = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ssi_pkg::QPTR_W'(ssi_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ssi_pkg::QPTR_W'(ssi_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/ssi_back.sv @@
// back end: list memories, counts, merge walk sequencer and result register
// depends on ssi_pkg; takes commands from ssi_queue
module ssi_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  ssi_pkg::qentry_type  q_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ssi_pkg::rsp_type     rsp_item
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_CMP   = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic [ssi_pkg::CNT_W-1:0]          count_a_ff, count_a_in;
   logic [ssi_pkg::CNT_W-1:0]          count_b_ff, count_b_in;
   logic                               drop_ff, drop_in;
   logic                               ov_ff, ov_in;
   logic [ssi_pkg::CNT_W-1:0]          i_ff, i_in;
   logic [ssi_pkg::CNT_W-1:0]          j_ff, j_in;
   logic signed [ssi_pkg::VALUE_W-1:0] held_ff, held_in;
   logic                               have_held_ff, have_held_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   ssi_pkg::rsp_type                   rsp_item_ff, rsp_item_in;

   logic signed [ssi_pkg::VALUE_W-1:0] mem_a_ff [ssi_pkg::LIST_DEPTH];
   logic signed [ssi_pkg::VALUE_W-1:0] mem_b_ff [ssi_pkg::LIST_DEPTH];
   logic signed [ssi_pkg::VALUE_W-1:0] rd_a_ff, rd_b_ff;

   logic                               wr_a, wr_b;
   logic                               out_free;
   logic [ssi_pkg::CNT_W-1:0]          i_step, j_step;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      drop_in      = drop_ff;
      ov_in        = ov_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      held_in      = held_ff;
      have_held_in = have_held_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      pop          = 1'b0;
      wr_a         = 1'b0;
      wr_b         = 1'b0;
      i_step       = i_ff;
      j_step       = j_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               case (q_entry.cmd)
                  ssi_pkg::CMD_LOAD_A: begin
                     if (count_a_ff < ssi_pkg::CNT_W'(ssi_pkg::LIST_DEPTH)) begin
                        wr_a       = 1'b1;
                        count_a_in = count_a_ff + 1'b1;
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  ssi_pkg::CMD_LOAD_B: begin
                     if (count_b_ff < ssi_pkg::CNT_W'(ssi_pkg::LIST_DEPTH)) begin
                        wr_b       = 1'b1;
                        count_b_in = count_b_ff + 1'b1;
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  ssi_pkg::CMD_START: begin
                     ov_in        = drop_ff;
                     i_in         = '0;
                     j_in         = '0;
                     have_held_in = 1'b0;
                     if (count_a_ff == '0 || count_b_ff == '0) begin
                        state_in = ST_FLUSH;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // a match goes to the holding slot; the previous match leaves as non-last
            if (rd_a_ff == rd_b_ff) begin
               if (!have_held_ff || out_free) begin
                  if (have_held_ff) begin
                     rsp_valid_in             = 1'b1;
                     rsp_item_in.common_value = held_ff;
                     rsp_item_in.last         = 1'b0;
                     rsp_item_in.empty_res    = 1'b0;
                     rsp_item_in.overflow     = ov_ff;
                  end
                  held_in      = rd_a_ff;
                  have_held_in = 1'b1;
                  i_step       = i_ff + 1'b1;
                  j_step       = j_ff + 1'b1;
               end
            end else if (rd_a_ff < rd_b_ff) begin
               i_step = i_ff + 1'b1;
            end else begin
               j_step = j_ff + 1'b1;
            end
            i_in = i_step;
            j_in = j_step;
            if (i_step >= count_a_ff || j_step >= count_b_ff) begin
               state_in = ST_FLUSH;
            end else if (i_step != i_ff || j_step != j_ff) begin
               state_in = ST_READ;
            end
         end
         ST_FLUSH: begin
            // final result: held match or the empty marker
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.common_value = have_held_ff ? held_ff : '0;
               rsp_item_in.last         = 1'b1;
               rsp_item_in.empty_res    = !have_held_ff;
               rsp_item_in.overflow     = ov_ff;
               count_a_in               = '0;
               count_b_in               = '0;
               drop_in                  = 1'b0;
               have_held_in             = 1'b0;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         drop_ff      <= 1'b0;
         have_held_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         drop_ff      <= drop_in;
         have_held_ff <= have_held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk data and result payload
   always_ff @(posedge clock) begin
      ov_ff       <= ov_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      held_ff     <= held_in;
      rsp_item_ff <= rsp_item_in;
   end

   // list memories, one write port and one registered read port each
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a_ff[count_a_ff[ssi_pkg::IDX_W-1:0]] <= q_entry.value;
      end
      rd_a_ff <= mem_a_ff[i_ff[ssi_pkg::IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b_ff[count_b_ff[ssi_pkg::IDX_W-1:0]] <= q_entry.value;
      end
      rd_b_ff <= mem_b_ff[j_ff[ssi_pkg::IDX_W-1:0]];
   end

endmodule

@@ rtl/ssi_checker.sv @@
// port-level checks for sorted_set_intersection, attached by bind
// depends on ssi_pkg
module ssi_port_checks (
   input  logic              clock,
   input  logic              reset,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  ssi_pkg::rsp_type  rsp_item
);

   // no result item straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item valid right after reset");

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result item changed");

   // the empty marker is always the final item of its start
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.empty_res |-> rsp_item.last)
      else $error("empty result item not marked last");

   // the empty marker carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.empty_res |-> rsp_item.common_value == '0)
      else $error("empty result item with nonzero value");

endmodule

bind sorted_set_intersection ssi_port_checks u_ssi_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
